FILE: rtl/core/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console cursor and scroll unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// fixed field widths
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CIDX_W = 11;
	localparam int OP_W   = 2;
	localparam int CFG_IDX_W = 1;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUT_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
	localparam logic [OP_W-1:0] OP_STATUS   = 2'd2;
	localparam logic [OP_W-1:0] OP_READ     = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_ATTR = 1'd1;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

	// tab stops every eight columns
	localparam logic [COL_W:0] TAB_STEP = 8'd8;
	localparam logic [COL_W:0] TAB_MASK = ~(8'd8 - 8'd1);

	// attribute and cell reset values
	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST   = 8'h0F;
	localparam logic [ATTR_W-1:0] STATUS_ATTR_RST = 8'h1F;
	localparam logic [CELL_W-1:0] INIT_STATUS_CELL = 16'h1F20;
	localparam logic [CELL_W-1:0] INIT_TEXT_CELL   = 16'h0F20;

	// sweep unit commands
	typedef enum logic [1:0] {
		SW_INIT = 2'd0,	// reset fill of the store
		SW_COPY = 2'd1,	// move cells up one row
		SW_ATTR = 2'd2,	// restamp status row attribute
		SW_FILL = 2'd3	// write blanks
	} sweep_mode_t;

	typedef struct packed {
		logic        go;
		sweep_mode_t mode;
	} sweep_ctl_t;

endpackage

FILE: rtl/core/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/tccs_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_sweep
// Address walker over a range of the screen store: one cell per cycle,
// read in one cycle and written in the next.
// ----------------------------------------------------------------------------
module tccs_sweep #(
	parameter int COLUMNS = 80,
	parameter int CELLS   = 2000
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tccs_pkg::sweep_ctl_t         ctl,
	input  logic [$clog2(CELLS)-1:0]     first,
	input  logic [$clog2(CELLS)-1:0]     last,
	input  logic [tccs_pkg::ATTR_W-1:0]  text_attr,
	input  logic [tccs_pkg::ATTR_W-1:0]  status_attr,
	input  logic [tccs_pkg::CELL_W-1:0]  rdata,
	output logic                         re,
	output logic [$clog2(CELLS)-1:0]     raddr,
	output logic                         we,
	output logic [$clog2(CELLS)-1:0]     waddr,
	output logic [tccs_pkg::CELL_W-1:0]  wdata,
	output logic                         done
);

	localparam int AW = $clog2(CELLS);

	logic                  active_q;
	logic                  wv_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         last_q;
	logic [AW-1:0]         waddr_q;
	tccs_pkg::sweep_mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			wv_q     <= 1'b0;
		end else if (ctl.go) begin
			active_q <= 1'b1;
			wv_q     <= 1'b0;
		end else begin
			wv_q <= active_q;
			if (active_q && ptr_q == last_q) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			ptr_q  <= first;
			last_q <= last;
			mode_q <= ctl.mode;
		end else if (active_q) begin
			ptr_q <= ptr_q + AW'(1);
			// copy writes one row above the source
			waddr_q <= (mode_q == tccs_pkg::SW_COPY) ? ptr_q - AW'(COLUMNS) : ptr_q;
		end
	end

	assign re    = active_q && (mode_q == tccs_pkg::SW_COPY || mode_q == tccs_pkg::SW_ATTR);
	assign raddr = ptr_q;
	assign we    = wv_q;
	assign waddr = waddr_q;
	assign done  = wv_q && !active_q;

	always_comb begin
		unique case (mode_q)
			tccs_pkg::SW_INIT: begin
				wdata = (waddr_q < AW'(COLUMNS)) ? tccs_pkg::INIT_STATUS_CELL
				                                  : tccs_pkg::INIT_TEXT_CELL;
			end
			tccs_pkg::SW_COPY: begin
				wdata = rdata;
			end
			tccs_pkg::SW_ATTR: begin
				wdata = {status_attr, rdata[tccs_pkg::CHAR_W-1:0]};
			end
			tccs_pkg::SW_FILL: begin
				wdata = {text_attr, tccs_pkg::CH_SPACE};
			end
			default: begin
				wdata = {text_attr, tccs_pkg::CH_SPACE};
			end
		endcase
	end

endmodule

FILE: rtl/core/text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console engine: screen store of character/attribute cells, a cursor,
// put-char with wrap and scroll, clear, status row write and cell read.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Word
// -------   ---------  ---------------------  -------------------------------
// command   in         start & !busy          opcode, char_code, row, col
// result    out        done (one cycle)       cell_value, cursor_index,
//                                             cursor_col, cursor_row, scrolled
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Put-char, status write and cell read: the accept moves the sequencer to
// ST_RESULT, where busy is high for one cycle and done and the result word
// are registered. A scroll first copies text rows up and blanks the last
// row; a clear first restamps the status row and blanks the text rows. Both
// walk the store one cell per cycle through the sweep unit and its single
// RAM port pair. After reset the store is filled with busy high; config
// writes are taken at any time. The receiver cannot stall done.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command
	input  logic                           start,
	output logic                           busy,
	input  logic [tccs_pkg::OP_W-1:0]      opcode,
	input  logic [tccs_pkg::CHAR_W-1:0]    char_code,
	input  logic [tccs_pkg::ROW_W-1:0]     row,
	input  logic [tccs_pkg::COL_W-1:0]     col,
	// result
	output logic                           done,
	output logic [tccs_pkg::CELL_W-1:0]    cell_value,
	output logic [tccs_pkg::CIDX_W-1:0]    cursor_index,
	output logic [tccs_pkg::COL_W-1:0]     cursor_col,
	output logic [tccs_pkg::ROW_W-1:0]     cursor_row,
	output logic                           scrolled,
	// config
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccs_pkg::ATTR_W-1:0]    cfg_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = tccs_pkg::COL_W;
	localparam int RW    = tccs_pkg::ROW_W;

	// sweep ranges
	localparam logic [AW-1:0] COPY_FIRST  = AW'(2 * COLUMNS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW0   = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] STATUS_LAST = AW'(COLUMNS - 1);
	localparam logic [AW-1:0] TEXT_FIRST  = AW'(COLUMNS);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,	// reset fill
		ST_IDLE   = 7'b0000010,
		ST_RESULT = 7'b0000100,	// register the result word
		ST_SCROLL = 7'b0001000,	// copy rows up
		ST_BLANK  = 7'b0010000,	// blank last row
		ST_STATUS = 7'b0100000,	// restamp status attributes
		ST_CLEAR  = 7'b1000000	// blank text rows
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 cur_col_q;
	logic [RW-1:0]                 cur_row_q;
	logic [tccs_pkg::ATTR_W-1:0]   text_attr_q;
	logic [tccs_pkg::ATTR_W-1:0]   status_attr_q;
	tccs_pkg::sweep_ctl_t          sw_ctl_q;
	logic [AW-1:0]                 sw_first_q;
	logic [AW-1:0]                 sw_last_q;
	logic                          done_q;
	logic                          scroll_q;
	logic                          cell_sel_q;

	logic [tccs_pkg::CELL_W-1:0]   cell_value_q;
	logic [tccs_pkg::CIDX_W-1:0]   cursor_index_q;
	logic [CW-1:0]                 cursor_col_q;
	logic [RW-1:0]                 cursor_row_q;
	logic                          scrolled_q;

	logic                          accept;
	logic                          printable;
	logic [CW:0]                   ncol;
	logic [RW:0]                   nrow;
	logic                          need_scroll;
	logic                          col_ok;
	logic                          row_ok;
	logic [AW-1:0]                 cur_addr;
	logic [AW-1:0]                 rd_addr;

	// store ports
	logic                          top_we;
	logic [AW-1:0]                 top_waddr;
	logic [tccs_pkg::CELL_W-1:0]   top_wdata;
	logic                          top_re;
	logic                          sw_we;
	logic [AW-1:0]                 sw_waddr;
	logic [tccs_pkg::CELL_W-1:0]   sw_wdata;
	logic                          sw_re;
	logic [AW-1:0]                 sw_raddr;
	logic                          sw_done;
	logic                          sweep_owns;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [tccs_pkg::CELL_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [tccs_pkg::CELL_W-1:0]   ram_rdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// linear cell addresses (multiply by a constant)
	assign cur_addr = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);
	assign rd_addr  = AW'(row) * AW'(COLUMNS) + AW'(col);
	assign col_ok   = {1'b0, col} < (CW + 1)'(COLUMNS);
	assign row_ok   = {1'b0, row} < (RW + 1)'(ROWS);

	// put-char cursor motion
	always_comb begin
		ncol      = {1'b0, cur_col_q};
		nrow      = {1'b0, cur_row_q};
		printable = 1'b0;
		case (char_code) inside
			tccs_pkg::CH_BS: begin
				if (cur_col_q != '0) begin
					ncol = {1'b0, cur_col_q} - (CW + 1)'(1);
				end
			end
			tccs_pkg::CH_TAB: begin
				ncol = ({1'b0, cur_col_q} + tccs_pkg::TAB_STEP) & tccs_pkg::TAB_MASK;
			end
			tccs_pkg::CH_CR: begin
				ncol = '0;
			end
			tccs_pkg::CH_LF: begin
				ncol = '0;
				nrow = {1'b0, cur_row_q} + (RW + 1)'(1);
			end
			[tccs_pkg::CH_SPACE:tccs_pkg::CH_LAST_PRINT]: begin
				printable = 1'b1;
				ncol      = {1'b0, cur_col_q} + (CW + 1)'(1);
			end
			default: begin
				printable = 1'b0;	// ignored codes still run the wrap check
			end
		endcase
		// right edge wrap
		if (ncol >= (CW + 1)'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + (RW + 1)'(1);
		end
	end

	assign need_scroll = nrow >= (RW + 1)'(ROWS);

	// direct cell accesses at accept time
	always_comb begin
		top_we    = 1'b0;
		top_waddr = cur_addr;
		top_wdata = {text_attr_q, char_code};
		if (accept && opcode == tccs_pkg::OP_PUT_CHAR && printable) begin
			top_we = 1'b1;
		end else if (accept && opcode == tccs_pkg::OP_STATUS && col_ok) begin
			top_we    = 1'b1;
			top_waddr = AW'(col);
			top_wdata = {status_attr_q, char_code};
		end
	end

	assign top_re = accept && (opcode == tccs_pkg::OP_READ);

	// sweep states hand both store ports to the sweep unit
	assign sweep_owns = !(state_q == ST_IDLE || state_q == ST_RESULT);
	assign ram_we     = sweep_owns ? sw_we    : top_we;
	assign ram_waddr  = sweep_owns ? sw_waddr : top_waddr;
	assign ram_wdata  = sweep_owns ? sw_wdata : top_wdata;
	assign ram_re     = sweep_owns ? sw_re    : top_re;
	assign ram_raddr  = sweep_owns ? sw_raddr : rd_addr;

	tccs_ram #(
		.WIDTH (tccs_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tccs_sweep #(
		.COLUMNS (COLUMNS),
		.CELLS   (CELLS)
	) u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (sw_ctl_q),
		.first       (sw_first_q),
		.last        (sw_last_q),
		.text_attr   (text_attr_q),
		.status_attr (status_attr_q),
		.rdata       (ram_rdata),
		.re          (sw_re),
		.raddr       (sw_raddr),
		.we          (sw_we),
		.waddr       (sw_waddr),
		.wdata       (sw_wdata),
		.done        (sw_done)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q   <= tccs_pkg::TEXT_ATTR_RST;
			status_attr_q <= tccs_pkg::STATUS_ATTR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tccs_pkg::REG_TEXT_ATTR:   text_attr_q   <= cfg_data;
				tccs_pkg::REG_STATUS_ATTR: status_attr_q <= cfg_data;
				default: begin
					text_attr_q <= text_attr_q;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			cur_col_q     <= '0;
			cur_row_q     <= RW'(1);
			sw_ctl_q.go   <= 1'b1;	// reset fill starts at once
			sw_ctl_q.mode <= tccs_pkg::SW_INIT;
			sw_first_q    <= '0;
			sw_last_q     <= LAST_CELL;
			done_q        <= 1'b0;
			scroll_q      <= 1'b0;
			cell_sel_q    <= 1'b0;
		end else begin
			sw_ctl_q.go <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if (sw_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						scroll_q   <= 1'b0;
						cell_sel_q <= (opcode == tccs_pkg::OP_READ) && row_ok && col_ok;
						state_q    <= ST_RESULT;
						unique case (opcode)
							tccs_pkg::OP_PUT_CHAR: begin
								cur_col_q <= ncol[CW-1:0];
								if (need_scroll) begin
									cur_row_q     <= RW'(ROWS - 1);
									scroll_q      <= 1'b1;
									sw_ctl_q.go   <= 1'b1;
									sw_ctl_q.mode <= tccs_pkg::SW_COPY;
									sw_first_q    <= COPY_FIRST;
									sw_last_q     <= LAST_CELL;
									state_q       <= ST_SCROLL;
								end else begin
									cur_row_q <= nrow[RW-1:0];
								end
							end
							tccs_pkg::OP_CLEAR: begin
								cur_col_q     <= '0;
								cur_row_q     <= '0;
								sw_ctl_q.go   <= 1'b1;
								sw_ctl_q.mode <= tccs_pkg::SW_ATTR;
								sw_first_q    <= '0;
								sw_last_q     <= STATUS_LAST;
								state_q       <= ST_STATUS;
							end
							default: begin
								state_q <= ST_RESULT;	// status write and read
							end
						endcase
					end
				end
				ST_SCROLL: begin
					if (sw_done) begin
						sw_ctl_q.go   <= 1'b1;
						sw_ctl_q.mode <= tccs_pkg::SW_FILL;
						sw_first_q    <= LAST_ROW0;
						sw_last_q     <= LAST_CELL;
						state_q       <= ST_BLANK;
					end
				end
				ST_STATUS: begin
					if (sw_done) begin
						sw_ctl_q.go   <= 1'b1;
						sw_ctl_q.mode <= tccs_pkg::SW_FILL;
						sw_first_q    <= TEXT_FIRST;
						sw_last_q     <= LAST_CELL;
						state_q       <= ST_CLEAR;
					end
				end
				ST_BLANK, ST_CLEAR: begin
					if (sw_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word; read data is valid in the result cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			cell_value_q   <= cell_sel_q ? ram_rdata : '0;
			cursor_index_q <= tccs_pkg::CIDX_W'(cur_addr);
			cursor_col_q   <= cur_col_q;
			cursor_row_q   <= cur_row_q;
			scrolled_q     <= scroll_q;
		end
	end

	assign done         = done_q;
	assign cell_value   = cell_value_q;
	assign cursor_index = cursor_index_q;
	assign cursor_col   = cursor_col_q;
	assign cursor_row   = cursor_row_q;
	assign scrolled     = scrolled_q;

endmodule

FILE: bench/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit_tb
// Self-checking bench for the text console unit. A directed table covers
// reset contents, field extremes, every opcode and control code, edge wrap,
// scroll, clear and put-char on the status row. Three random phases follow,
// each under its own attribute setting and sender idle rate. Every done word
// is checked against a hand-written result or a model of screen and cursor.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_tb;

	import tccs_pkg::*;

	localparam int COLUMNS        = 80;
	localparam int ROWS           = 25;
	localparam int CELLS          = COLUMNS * ROWS;
	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 11;
	localparam int TAB_STOP       = 8;
	// quiet time allowed: a clear or scroll walks about 2000 cells, the
	// reset fill about as many; this is several times the worst of them
	localparam int WATCHDOG_LIMIT = 20000;
	// result is registered in the result state after the start word is taken
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_WORDS    = 380;
	localparam int DIR_ROWS       = 26;
	localparam int MAX_REPORTS    = 10;

	// one command word and one result word, in port order
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cval;
		logic [CIDX_W-1:0] cidx;
		logic [COL_W-1:0]  ccol;
		logic [ROW_W-1:0]  crow;
		logic              scr;
	} console_view_t;

	// directed row: command, repeat count, and a hand-written result
	// where the answer is obvious (otherwise the model decides)
	typedef struct packed {
		console_cmd_t  cmd;
		logic [5:0]    reps;
		logic          typed;
		console_view_t want;
	} dir_step_t;

	localparam dir_step_t DIRECTED [DIR_ROWS] = '{
		// reset image: status row 0x1F20, text 0x0F20, cursor at row 1
		'{'{OP_READ, 8'h00, 5'd0, 7'd0}, 6'd1, 1'b1, '{16'h1F20, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_READ, 8'hFF, 5'd24, 7'd79}, 6'd1, 1'b1, '{16'h0F20, 11'd80, 7'd0, 5'd1, 1'b0}},
		// reads off the screen return zero
		'{'{OP_READ, 8'h00, 5'd25, 7'd0}, 6'd1, 1'b1, '{16'h0000, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_READ, 8'h00, 5'd31, 7'd127}, 6'd1, 1'b1, '{16'h0000, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_READ, 8'h00, 5'd0, 7'd80}, 6'd1, 1'b1, '{16'h0000, 11'd80, 7'd0, 5'd1, 1'b0}},
		// status write, in range and past the right edge (dropped)
		'{'{OP_STATUS, 8'hFF, 5'd31, 7'd79}, 6'd1, 1'b1, '{16'h0000, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_STATUS, 8'h41, 5'd0, 7'd127}, 6'd1, 1'b1, '{16'h0000, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_READ, 8'h00, 5'd0, 7'd79}, 6'd1, 1'b1, '{16'h1FFF, 11'd80, 7'd0, 5'd1, 1'b0}},
		'{'{OP_PUT_CHAR, 8'h41, 5'd0, 7'd0}, 6'd1, 1'b1, '{16'h0000, 11'd81, 7'd1, 5'd1, 1'b0}},
		// last printable, then codes that only run the wrap/scroll checks
		'{'{OP_PUT_CHAR, CH_LAST_PRINT, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, 8'h80, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, 8'hFF, 5'd31, 7'd127}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, 8'h00, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, 8'h1B, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		// cursor controls; second backspace sits at column 0
		'{'{OP_PUT_CHAR, CH_BS, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, CH_TAB, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, CH_CR, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, CH_BS, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, CH_SPACE, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		// tab run past the right edge wraps the line
		'{'{OP_PUT_CHAR, CH_TAB, 5'd0, 7'd0}, 6'd10, 1'b0, '0},
		// enough newlines to push past the last row and scroll
		'{'{OP_PUT_CHAR, CH_LF, 5'd0, 7'd0}, 6'd24, 1'b0, '0},
		'{'{OP_READ, 8'h00, 5'd1, 7'd0}, 6'd1, 1'b0, '0},
		// clear homes the cursor onto the status row
		'{'{OP_CLEAR, 8'h5A, 5'd3, 7'd9}, 6'd1, 1'b1, '{16'h0000, 11'd0, 7'd0, 5'd0, 1'b0}},
		'{'{OP_PUT_CHAR, 8'h5A, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_READ, 8'h00, 5'd0, 7'd0}, 6'd1, 1'b0, '0},
		'{'{OP_PUT_CHAR, CH_LF, 5'd0, 7'd0}, 6'd1, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      opcode;
	logic [CHAR_W-1:0]    char_code;
	logic [ROW_W-1:0]     row;
	logic [COL_W-1:0]     col;
	logic                 done;
	logic [CELL_W-1:0]    cell_value;
	logic [CIDX_W-1:0]    cursor_index;
	logic [COL_W-1:0]     cursor_col;
	logic [ROW_W-1:0]     cursor_row;
	logic                 scrolled;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ATTR_W-1:0]    cfg_data;

	// model of the block: screen image, cursor, attribute registers
	logic [CELL_W-1:0] image_cells [CELLS];
	int                at_col;
	int                at_row;
	logic [ATTR_W-1:0] attr_text;
	logic [ATTR_W-1:0] attr_status;

	console_view_t expected_views [$];
	int            fail_count = 0;
	int            quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	text_console_cursor_scroll_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.char_code(char_code),
		.row(row),
		.col(col),
		.done(done),
		.cell_value(cell_value),
		.cursor_index(cursor_index),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.scrolled(scrolled),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Apply one command to the model and return the word the block should
	// report for it.
	function automatic console_view_t console_apply(console_cmd_t c);
		console_view_t v;
		int            k;
		v = '0;
		case (c.op)
			OP_PUT_CHAR: begin
				if (c.ch == CH_BS) begin
					if (at_col != 0) at_col--;
				end else if (c.ch == CH_TAB) begin
					at_col = (at_col + TAB_STOP) & ~(TAB_STOP - 1);
				end else if (c.ch == CH_CR) begin
					at_col = 0;
				end else if (c.ch == CH_LF) begin
					at_col = 0;
					at_row++;
				end else if (c.ch >= CH_SPACE && c.ch <= CH_LAST_PRINT) begin
					// row 0 is fair game here: cursor lands there after a clear
					image_cells[at_row * COLUMNS + at_col] = {attr_text, c.ch};
					at_col++;
				end
				// wrap and scroll run for every code, ignored ones too
				if (at_col >= COLUMNS) begin
					at_col = 0;
					at_row++;
				end
				if (at_row >= ROWS) begin
					// status row stays; text rows shift up; last row blanked
					for (k = COLUMNS; k < (ROWS - 1) * COLUMNS; k++)
						image_cells[k] = image_cells[k + COLUMNS];
					for (k = (ROWS - 1) * COLUMNS; k < CELLS; k++)
						image_cells[k] = {attr_text, CH_SPACE};
					at_row = ROWS - 1;
					v.scr  = 1'b1;
				end
			end
			OP_CLEAR: begin
				// status row keeps its characters, takes the status attribute
				for (k = 0; k < COLUMNS; k++)
					image_cells[k] = {attr_status, image_cells[k][CHAR_W-1:0]};
				for (k = COLUMNS; k < CELLS; k++)
					image_cells[k] = {attr_text, CH_SPACE};
				at_col = 0;
				at_row = 0;
			end
			OP_STATUS: begin
				if (int'(c.col) < COLUMNS)
					image_cells[c.col] = {attr_status, c.ch};
			end
			default: begin
				if (int'(c.row) < ROWS && int'(c.col) < COLUMNS)
					v.cval = image_cells[int'(c.row) * COLUMNS + int'(c.col)];
			end
		endcase
		v.cidx = CIDX_W'(at_row * COLUMNS + at_col);
		v.ccol = COL_W'(at_col);
		v.crow = ROW_W'(at_row);
		return v;
	endfunction

	// Present one command word, after an optional gap, and hold it until
	// start & !busy is seen at an edge. start is left high so the next word
	// can follow back to back; gaps and the drain lower it.
	task automatic issue_word(console_cmd_t c, int gap_pct, logic typed, console_view_t want);
		console_view_t v;
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= c.op;
		char_code <= c.ch;
		row       <= c.row;
		col       <= c.col;
		@(posedge clk);
		while (busy) @(posedge clk);
		v = console_apply(c);
		expected_views.push_back(typed ? want : v);
	endtask

	// Stop issuing and wait for every outstanding result, then let the block
	// settle so it is quiet before anything else happens.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result checker: done marks a word valid for exactly one cycle.
	always @(posedge clk) begin : result_check
		console_view_t got;
		console_view_t want;
		if (arst_n && done) begin
			got = {cell_value, cursor_index, cursor_col, cursor_row, scrolled};
			if (expected_views.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t: unexpected result word cell=%h idx=%0d col=%0d row=%0d scr=%b",
						$realtime, got.cval, got.cidx, got.ccol, got.crow, got.scr);
				fail_count++;
			end else begin
				want = expected_views.pop_front();
				if (got.cval !== want.cval || got.cidx !== want.cidx ||
						got.ccol !== want.ccol || got.crow !== want.crow ||
						got.scr !== want.scr) begin
					if (fail_count < MAX_REPORTS) begin
						$write("%0t: mismatch exp cell=%h idx=%0d col=%0d row=%0d scr=%b",
							$realtime, want.cval, want.cidx, want.ccol, want.crow, want.scr);
						$display(" got cell=%h idx=%0d col=%0d row=%0d scr=%b",
							got.cval, got.cidx, got.ccol, got.crow, got.scr);
					end
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any accepted word on any channel counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding",
				$realtime, expected_views.size());
			$display("text_console_cursor_scroll_unit test failed");
			$finish;
		end
	end

	initial begin : stimulus
		console_cmd_t c;
		int           ph;
		int           r;
		int           k;
		int           sent;
		int           pick;
		int           line_left;
		int           idle_pct;
		logic [ATTR_W-1:0] ta;
		logic [ATTR_W-1:0] sa;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		opcode    <= OP_PUT_CHAR;
		char_code <= '0;
		row       <= '0;
		col       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TEXT_ATTR;
		cfg_data  <= '0;

		// model reset image
		for (k = 0; k < CELLS; k++)
			image_cells[k] = (k < COLUMNS) ? INIT_STATUS_CELL : INIT_TEXT_CELL;
		at_col      = 0;
		at_row      = 1;
		attr_text   = TEXT_ATTR_RST;
		attr_status = STATUS_ATTR_RST;
		line_left   = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, run under reset attributes; busy covers the
		// post-reset fill so the first word simply waits for it
		for (r = 0; r < DIR_ROWS; r++)
			for (k = 0; k < int'(DIRECTED[r].reps); k++)
				issue_word(DIRECTED[r].cmd, 15, DIRECTED[r].typed, DIRECTED[r].want);

		// random phases: attribute extremes both ways, then random values;
		// sender idles 15%, then 79%, then never
		for (ph = 0; ph < 3; ph++) begin
			wait_idle();
			case (ph)
				0: begin ta = '0;  sa = '1;  idle_pct = 15; end
				1: begin ta = '1;  sa = '0;  idle_pct = 79; end
				default: begin
					ta = ATTR_W'($urandom);
					sa = ATTR_W'($urandom);
					idle_pct = 0;
				end
			endcase
			// both registers in one valid burst, valid held high between them
			cfg_valid <= 1'b1;
			cfg_index <= REG_TEXT_ATTR;
			cfg_data  <= ta;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			attr_text = ta;
			cfg_index <= REG_STATUS_ATTR;
			cfg_data  <= sa;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			attr_status = sa;
			cfg_valid <= 1'b0;

			// Mostly lines of text ending in LF (sometimes CR first), with
			// tabs and backspaces inside, reads near the cursor, status
			// writes, rare clears, and some ignored codes as noise. Fields
			// an opcode does not use carry random bits.
			sent = 0;
			while (sent < PHASE_WORDS) begin
				c.op  = OP_PUT_CHAR;
				c.ch  = CHAR_W'($urandom);
				c.row = ROW_W'($urandom);
				c.col = COL_W'($urandom);
				pick  = $urandom_range(0, 99);
				if (line_left == 0) begin
					if (pick < 25) begin
						c.ch = CH_CR;
					end else begin
						c.ch = CH_LF;
						// mix of short lines and ones long enough to wrap
						line_left = ($urandom_range(0, 99) < 40) ? int'($urandom_range(0, 12))
							: int'($urandom_range(13, 110));
					end
				end else if (pick < 62) begin
					c.ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST_PRINT));
					line_left--;
				end else if (pick < 66) begin
					c.ch = CH_TAB;
					line_left--;
				end else if (pick < 70) begin
					c.ch = CH_BS;
				end else if (pick < 79) begin
					c.op  = OP_READ;
					c.row = ($urandom_range(0, 1) != 0) ? ROW_W'(at_row)
						: ROW_W'($urandom_range(0, ROWS - 1));
					c.col = COL_W'($urandom_range(0, COLUMNS - 1));
				end else if (pick < 82) begin
					// any row/col, off-screen included
					c.op = OP_READ;
				end else if (pick < 88) begin
					c.op = OP_STATUS;
					if (pick < 86) c.col = COL_W'($urandom_range(0, COLUMNS - 1));
				end else if (pick < 89) begin
					c.op = OP_CLEAR;
				end else begin
					if (pick < 94) begin
						c.ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
					end else begin
						do c.ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
						while (c.ch inside {CH_BS, CH_TAB, CH_LF, CH_CR});
					end
				end
				issue_word(c, idle_pct, 1'b0, '0);
				sent++;
			end
		end

		wait_idle();
		if (fail_count == 0 && expected_views.size() == 0) begin
			$display("text_console_cursor_scroll_unit test passed");
		end else begin
			$display("text_console_cursor_scroll_unit test failed");
		end
		$finish;
	end

endmodule
